@@ rtl/lmcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmcc_pkg
// Types and constants shared by the indicator led mode and color controller.
// ----------------------------------------------------------------------------
package lmcc_pkg;

	localparam int unsigned DUTY_W = 12;
	localparam int unsigned HUE_W  = 9;
	localparam int unsigned COMP_W = 7;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned BTN_W  = 2;
	localparam int unsigned CIDX_W = 3;

	// mode codes, as seen on the current_mode field
	localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HUE     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SAT     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_VAL     = 2'd3;

	// button codes
	localparam logic [BTN_W-1:0] BTN_DOUBLE = 2'd1;
	localparam logic [BTN_W-1:0] BTN_LONG   = 2'd2;

	// opcodes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_BUTTON = 1'b1;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_INDICATOR_TOP = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_HUE_STEP      = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_SAT_STEP      = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_VAL_DUTY      = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_SAT_LIMIT     = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_VAL_LIMIT     = 3'd5;

	localparam logic [HUE_W-1:0]  HUE_WRAP   = 9'd360;
	localparam logic [HUE_W-1:0]  HUE_RESET  = 9'd292;
	localparam logic [COMP_W-1:0] COMP_RESET = 7'd100;
	localparam logic [COMP_W-1:0] COMP_MAX   = 7'd127;

	localparam logic [DUTY_W-1:0] TOP_RESET      = 12'd1000;
	localparam logic [DUTY_W-1:0] HUE_STEP_RESET = 12'd10;
	localparam logic [DUTY_W-1:0] SAT_STEP_RESET = 12'd50;
	localparam logic [DUTY_W-1:0] VAL_DUTY_RESET = 12'd1000;

	typedef struct packed {
		logic [DUTY_W-1:0] indicator_top;
		logic [DUTY_W-1:0] hue_mode_step;
		logic [DUTY_W-1:0] saturation_mode_step;
		logic [DUTY_W-1:0] value_mode_duty;
		logic [COMP_W-1:0] saturation_limit;
		logic [COMP_W-1:0] value_limit;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DUTY_W-1:0] duty;
		logic              duty_rising;
		logic [DUTY_W-1:0] breath_step;
		logic [HUE_W-1:0]  hue;
		logic [COMP_W-1:0] sat;
		logic [COMP_W-1:0] val;
		logic              sat_rising;
		logic              val_rising;
	} state_t;

endpackage

@@ rtl/lmcc_cmd_if.sv @@
// ----------------------------------------------------------------------------
// lmcc_cmd_if
// Input channel: tick or button update beats.
// ----------------------------------------------------------------------------
interface lmcc_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [1:0] button;

	modport source (output valid, output opcode, output button, input ready);
	modport sink (input valid, input opcode, input button, output ready);
endinterface

@@ rtl/lmcc_res_if.sv @@
// ----------------------------------------------------------------------------
// lmcc_res_if
// Output channel: indicator duty, hsv color, mode and save request beats.
// ----------------------------------------------------------------------------
interface lmcc_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] indicator_duty;
	logic [8:0]  hue;
	logic [6:0]  saturation;
	logic [6:0]  brightness;
	logic [1:0]  current_mode;
	logic        save_request;

	modport source (output valid, output indicator_duty, output hue, output saturation,
		output brightness, output current_mode, output save_request, input ready);
	modport sink (input valid, input indicator_duty, input hue, input saturation,
		input brightness, input current_mode, input save_request, output ready);
endinterface

@@ rtl/led_mode_color_controller_unit.sv @@
// ----------------------------------------------------------------------------
// led_mode_color_controller_unit
// Indicator led mode controller with hsv color adjust.
//
//   channel  dir  beat contents
//   cmd      in   opcode (tick / button), button code
//   res      out  indicator_duty, hue, saturation, brightness, current_mode,
//                 save_request
//   cfg_*    in   register index, write data, write enable
//
// One beat per cycle sustained while res.ready holds. A command beat lands in an
// input register when it is accepted; the update logic then writes the state
// registers, which double as the result register, once the result register is
// free or being taken. With a result waiting, one more command is still taken
// into the input register. Reset loads the documented reset values; no clearing
// pass.
// ----------------------------------------------------------------------------
module led_mode_color_controller_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	lmcc_cmd_if.sink                    cmd,
	lmcc_res_if.source                  res,
	input  logic                        cfg_we,
	input  logic [lmcc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [lmcc_pkg::DUTY_W-1:0] cfg_data
);
	import lmcc_pkg::*;

	cfg_t             cfg_q;
	state_t           state_q;
	state_t           state_nxt;
	logic             save_nxt;
	logic             save_q;
	logic             res_valid_q;
	logic             valid_s1;
	logic             opcode_s1;
	logic [BTN_W-1:0] button_s1;
	logic             res_take;
	logic             adv_s1;

	assign res_take  = !res_valid_q || res.ready;
	assign adv_s1    = valid_s1 && res_take;
	assign cmd.ready = !valid_s1 || res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.indicator_top        <= TOP_RESET;
			cfg_q.hue_mode_step        <= HUE_STEP_RESET;
			cfg_q.saturation_mode_step <= SAT_STEP_RESET;
			cfg_q.value_mode_duty      <= VAL_DUTY_RESET;
			cfg_q.saturation_limit     <= COMP_RESET;
			cfg_q.value_limit          <= COMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INDICATOR_TOP: cfg_q.indicator_top        <= cfg_data;
				CFG_HUE_STEP:      cfg_q.hue_mode_step        <= cfg_data;
				CFG_SAT_STEP:      cfg_q.saturation_mode_step <= cfg_data;
				CFG_VAL_DUTY:      cfg_q.value_mode_duty      <= cfg_data;
				CFG_SAT_LIMIT:     cfg_q.saturation_limit     <= cfg_data[COMP_W-1:0];
				CFG_VAL_LIMIT:     cfg_q.value_limit          <= cfg_data[COMP_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			opcode_s1 <= cmd.opcode;
			button_s1 <= cmd.button;
		end
	end

	lmcc_update u_update (
		.cur    (state_q),
		.cfg    (cfg_q),
		.opcode (opcode_s1),
		.button (button_s1),
		.nxt    (state_nxt),
		.save   (save_nxt)
	);

	// state only moves when a new result is loaded, so it holds the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_DEFAULT;
			state_q.duty        <= '0;
			state_q.duty_rising <= 1'b1;
			state_q.breath_step <= '0;
			state_q.hue         <= HUE_RESET;
			state_q.sat         <= COMP_RESET;
			state_q.val         <= COMP_RESET;
			state_q.sat_rising  <= 1'b1;
			state_q.val_rising  <= 1'b1;
			save_q              <= 1'b0;
			res_valid_q         <= 1'b0;
		end else begin
			if (res_take) begin
				res_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
				save_q  <= save_nxt;
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.indicator_duty = state_q.duty;
	assign res.hue            = state_q.hue;
	assign res.saturation     = state_q.sat;
	assign res.brightness     = state_q.val;
	assign res.current_mode   = state_q.mode;
	assign res.save_request   = save_q;

endmodule

@@ rtl/lmcc_update.sv @@
// ----------------------------------------------------------------------------
// lmcc_update
// Next-state logic for one beat: duty triangle, color adjust and mode step.
// ----------------------------------------------------------------------------
module lmcc_update (
	input  lmcc_pkg::state_t          cur,
	input  lmcc_pkg::cfg_t            cfg,
	input  logic                      opcode,
	input  logic [lmcc_pkg::BTN_W-1:0] button,
	output lmcc_pkg::state_t          nxt,
	output logic                      save
);
	import lmcc_pkg::*;

	logic [DUTY_W:0]   duty_sum;
	logic [HUE_W-1:0]  hue_inc;
	logic [COMP_W-1:0] sat_new;
	logic [COMP_W-1:0] val_new;
	logic [MODE_W-1:0] mode_new;

	assign duty_sum = {1'b0, cur.duty} + {1'b0, cur.breath_step};
	assign hue_inc  = cur.hue + 9'd1;
	assign mode_new = (button == BTN_DOUBLE) ? cur.mode + 2'd1 : cur.mode;

	// bounce steps saturate at the field range
	always_comb begin
		if (cur.sat_rising) begin
			sat_new = (cur.sat < COMP_MAX) ? cur.sat + 7'd1 : cur.sat;
		end else begin
			sat_new = (cur.sat != '0) ? cur.sat - 7'd1 : cur.sat;
		end
		if (cur.val_rising) begin
			val_new = (cur.val < COMP_MAX) ? cur.val + 7'd1 : cur.val;
		end else begin
			val_new = (cur.val != '0) ? cur.val - 7'd1 : cur.val;
		end
	end

	always_comb begin
		nxt  = cur;
		save = 1'b0;
		if (opcode == OP_TICK) begin
			if (cur.breath_step != '0) begin
				if (cur.duty_rising) begin
					if (duty_sum <= {1'b0, cfg.indicator_top}) begin
						nxt.duty = duty_sum[DUTY_W-1:0];
					end else begin
						nxt.duty        = cfg.indicator_top;
						nxt.duty_rising = 1'b0;
					end
				end else begin
					if (cur.duty >= cur.breath_step) begin
						nxt.duty = cur.duty - cur.breath_step;
					end else begin
						nxt.duty        = '0;
						nxt.duty_rising = 1'b1;
					end
				end
			end
			if (button == BTN_LONG) begin
				unique case (cur.mode)
					MODE_HUE: begin
						nxt.hue = (hue_inc >= HUE_WRAP) ? '0 : hue_inc;
					end
					MODE_SAT: begin
						nxt.sat = sat_new;
						if (cur.sat_rising) begin
							if (sat_new >= cfg.saturation_limit) nxt.sat_rising = 1'b0;
						end else begin
							if (sat_new == '0) nxt.sat_rising = 1'b1;
						end
					end
					MODE_VAL: begin
						nxt.val = val_new;
						if (cur.val_rising) begin
							if (val_new >= cfg.value_limit) nxt.val_rising = 1'b0;
						end else begin
							if (val_new == '0) nxt.val_rising = 1'b1;
						end
					end
					default: begin
						nxt.hue = cur.hue;
					end
				endcase
			end
		end else begin
			nxt.mode = mode_new;
			save     = (button == BTN_DOUBLE) && (mode_new == MODE_DEFAULT);
			// re-sync the indicator to the mode
			unique case (mode_new)
				MODE_DEFAULT: begin
					nxt.breath_step = '0;
					nxt.duty        = '0;
				end
				MODE_HUE: begin
					nxt.breath_step = cfg.hue_mode_step;
				end
				MODE_SAT: begin
					nxt.breath_step = cfg.saturation_mode_step;
				end
				default: begin
					nxt.breath_step = '0;
					nxt.duty        = cfg.value_mode_duty;
				end
			endcase
		end
	end

endmodule
